>>> hdl/msbr_pkg.sv
package msbr_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_SLOTS_DEF      = 8;
	localparam int MAX_SLOT_BYTES_DEF = 64;

	// Field widths fixed by the item formats
	localparam int BYTE_W       = 8;
	localparam int LEN_W        = 7;
	localparam int SLOTS_CFG_W  = 4;
	localparam int BYTES_CFG_W  = 7;
	localparam int CFG_DATA_W   = 7;
	localparam int CFG_INDEX_W  = 1;

	// Command fields are sized for the largest ring the parameters allow
	localparam int CMD_SLOT_W = 6;
	localparam int CMD_POS_W  = 6;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_BYTES   = 1'b1;

	typedef enum logic [1:0] {
		STAT_DATA       = 2'd0,
		STAT_EMPTY      = 2'd1,
		STAT_BAD_LENGTH = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_STATUS = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] write_byte;
		logic [LEN_W-1:0]  read_length;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [BYTE_W-1:0] read_byte;
		logic              last;
	} rsp_t;

	typedef struct packed {
		cmd_kind_t             kind;
		status_t               status;
		logic [CMD_SLOT_W-1:0] slot;
		logic [CMD_POS_W-1:0]  pos;
		logic [BYTE_W-1:0]     data;
		logic [LEN_W-1:0]      len;
	} cmd_t;

	// Handshake between command queue and back end
	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

>>> hdl/msbr_front.sv
module msbr_front import msbr_pkg::*; #(
	parameter int MAX_SLOTS      = MAX_SLOTS_DEF,
	parameter int MAX_SLOT_BYTES = MAX_SLOT_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  req_t                   req,
	input  logic [SLOTS_CFG_W-1:0] slots_cfg,
	input  logic [BYTES_CFG_W-1:0] bytes_cfg,
	input  q_status_t              q_status,
	output logic                   cmd_push,
	output cmd_t                   cmd
);

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SCNT_W = SLOT_W + 1;
	localparam int POS_W  = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1;
	localparam int BCNT_W = POS_W + 1;

	logic [SLOT_W-1:0] write_slot_q;
	logic [SLOT_W-1:0] read_slot_q;
	logic [POS_W-1:0]  fill_q;

	logic [SCNT_W-1:0] eff_slots;
	logic [BCNT_W-1:0] eff_bytes;
	logic [SLOT_W-1:0] write_slot_next;
	logic [SLOT_W-1:0] read_slot_next;
	logic              fill_done;
	logic              bad_len;
	logic              empty;

	// Clamp the configuration into the legal range
	always_comb begin
		if (slots_cfg < 4'd2) begin
			eff_slots = SCNT_W'(2);
		end else if (8'(slots_cfg) > 8'(MAX_SLOTS)) begin
			eff_slots = SCNT_W'(MAX_SLOTS);
		end else begin
			eff_slots = SCNT_W'(slots_cfg);
		end
		if (bytes_cfg == '0) begin
			eff_bytes = BCNT_W'(1);
		end else if (8'(bytes_cfg) > 8'(MAX_SLOT_BYTES)) begin
			eff_bytes = BCNT_W'(MAX_SLOT_BYTES);
		end else begin
			eff_bytes = BCNT_W'(bytes_cfg);
		end
	end

	assign write_slot_next = (({1'b0, write_slot_q} + SCNT_W'(1)) >= eff_slots) ?
		'0 : write_slot_q + SLOT_W'(1);
	assign read_slot_next = (({1'b0, read_slot_q} + SCNT_W'(1)) >= eff_slots) ?
		'0 : read_slot_q + SLOT_W'(1);
	assign fill_done = ({1'b0, fill_q} + BCNT_W'(1)) >= eff_bytes;
	assign empty     = read_slot_q == write_slot_q;
	assign bad_len   = (req.read_length == '0) || (req.read_length > LEN_W'(eff_bytes));

	assign req_stall = q_status.full;
	assign cmd_push  = req_valid && !q_status.full;

	always_comb begin
		cmd.kind   = CMD_WRITE;
		cmd.status = STAT_DATA;
		cmd.slot   = CMD_SLOT_W'(write_slot_q);
		cmd.pos    = CMD_POS_W'(fill_q);
		cmd.data   = req.write_byte;
		cmd.len    = req.read_length;
		if (req.action == ACT_READ) begin
			cmd.slot = CMD_SLOT_W'(read_slot_q);
			cmd.pos  = '0;
			if (empty) begin
				cmd.kind   = CMD_STATUS;
				cmd.status = STAT_EMPTY;
			end else if (bad_len) begin
				cmd.kind   = CMD_STATUS;
				cmd.status = STAT_BAD_LENGTH;
			end else begin
				cmd.kind = CMD_READ;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			read_slot_q  <= '0;
			fill_q       <= '0;
		end else if (cmd_push) begin
			if (req.action == ACT_WRITE) begin
				if (fill_done) begin
					fill_q       <= '0;
					write_slot_q <= write_slot_next;
				end else begin
					fill_q <= fill_q + POS_W'(1);
				end
			end else if (!empty && !bad_len) begin
				read_slot_q <= read_slot_next;
			end
		end
	end

endmodule

>>> hdl/msbr_cmd_queue.sv
module msbr_cmd_queue import msbr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      cmd_in,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t q_status
);

	cmd_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head           = entries_q[rd_ptr_q];
	assign q_status.valid = count_q != 2'd0;
	assign q_status.full  = count_q == 2'd2;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> hdl/msbr_back.sv
module msbr_back import msbr_pkg::*; #(
	parameter int MAX_SLOTS      = MAX_SLOTS_DEF,
	parameter int MAX_SLOT_BYTES = MAX_SLOT_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  q_status_t q_status,
	output logic      pop,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_t      rsp
);

	localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int POS_W    = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1;
	localparam int DEPTH    = MAX_SLOTS * MAX_SLOT_BYTES;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int OF_DEPTH = 4;
	localparam int OF_PTR_W = 2;
	localparam int OF_CNT_W = 3;

	function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] s,
		input logic [POS_W-1:0] p);
		return ADDR_W'(32'(s) * 32'(MAX_SLOT_BYTES) + 32'(p));
	endfunction

	logic [BYTE_W-1:0] mem [DEPTH];

	logic              busy_q;
	logic [LEN_W-1:0]  k_q;
	logic [LEN_W-1:0]  len_q;
	logic [SLOT_W-1:0] slot_q;

	logic              rd_valid_s1;
	status_t           rd_status_s1;
	logic              rd_last_s1;
	logic [BYTE_W-1:0] rd_data_s1;

	rsp_t                ofifo_q [OF_DEPTH];
	logic [OF_PTR_W-1:0] of_wr_q;
	logic [OF_PTR_W-1:0] of_rd_q;
	logic [OF_CNT_W-1:0] of_count_q;

	logic              can_issue;
	logic              issue;
	status_t           issue_status;
	logic              issue_last;
	logic [ADDR_W-1:0] issue_addr;
	logic              mem_we;
	logic              start;
	logic              rsp_pop;
	rsp_t              of_entry;

	// Issue only while the output queue has room for everything in flight
	assign can_issue = ({1'b0, of_count_q} + (OF_CNT_W + 1)'(rd_valid_s1))
		<= (OF_CNT_W + 1)'(OF_DEPTH - 1);

	always_comb begin
		pop          = 1'b0;
		issue        = 1'b0;
		issue_status = STAT_DATA;
		issue_last   = 1'b0;
		issue_addr   = store_addr(slot_q, k_q[POS_W-1:0]);
		mem_we       = 1'b0;
		start        = 1'b0;
		if (busy_q) begin
			if (can_issue) begin
				issue      = 1'b1;
				issue_last = (k_q + LEN_W'(1)) == len_q;
			end
		end else if (q_status.valid) begin
			case (head.kind)
				CMD_WRITE: begin
					mem_we = 1'b1;
					pop    = 1'b1;
				end
				CMD_STATUS: begin
					if (can_issue) begin
						issue        = 1'b1;
						issue_status = head.status;
						issue_last   = 1'b1;
						pop          = 1'b1;
					end
				end
				CMD_READ: begin
					if (can_issue) begin
						issue      = 1'b1;
						issue_addr = store_addr(head.slot[SLOT_W-1:0], '0);
						issue_last = head.len == LEN_W'(1);
						start      = head.len != LEN_W'(1);
						pop        = 1'b1;
					end
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[store_addr(head.slot[SLOT_W-1:0], head.pos[POS_W-1:0])] <= head.data;
		end
		if (issue) begin
			rd_data_s1 <= mem[issue_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_status_s1 <= issue_status;
			rd_last_s1   <= issue_last;
		end
		if (start) begin
			len_q  <= head.len;
			slot_q <= head.slot[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= LEN_W'(1);
			end else if (busy_q && issue) begin
				k_q <= k_q + LEN_W'(1);
				if (issue_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		of_entry.status    = rd_status_s1;
		of_entry.read_byte = (rd_status_s1 == STAT_DATA) ? rd_data_s1 : '0;
		of_entry.last      = rd_last_s1;
	end

	assign rsp_valid = of_count_q != '0;
	assign rsp       = ofifo_q[of_rd_q];
	assign rsp_pop   = rsp_valid && !rsp_stall;

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			ofifo_q[of_wr_q] <= of_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			of_wr_q    <= '0;
			of_rd_q    <= '0;
			of_count_q <= '0;
		end else begin
			if (rd_valid_s1) begin
				of_wr_q <= of_wr_q + OF_PTR_W'(1);
			end
			if (rsp_pop) begin
				of_rd_q <= of_rd_q + OF_PTR_W'(1);
			end
			of_count_q <= of_count_q + OF_CNT_W'(rd_valid_s1) - OF_CNT_W'(rsp_pop);
		end
	end

endmodule

>>> hdl/multi_slot_buffer_ring.sv
// Channel  Direction  Handshake            Beat
// req      in         req_valid/req_stall  one write byte or one read request
// rsp      out        rsp_valid/rsp_stall  one data byte or one status word
// cfg      in         cfg_we               one register write, no wait
//
// A write is pushed at its accepting edge and reaches the store as it leaves the queue, once
// the back end is not busy. A read holds the back end until its last byte is issued: the
// single store read port streams one byte per cycle while the output queue has room. The first
// beat passes the command queue, the read stage and the output queue before it is offered.
// Reset clears the slot pointers, fill position and all queues; the store holds no reset value.
// req stalls only when the two-entry command queue is full; the back end holds off its store
// reads while the four-entry output queue cannot take the bytes in flight.
module multi_slot_buffer_ring import msbr_pkg::*; #(
	parameter int MAX_SLOTS      = MAX_SLOTS_DEF,
	parameter int MAX_SLOT_BYTES = MAX_SLOT_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  req_t                   req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output rsp_t                   rsp,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [SLOTS_CFG_W-1:0] slots_cfg_q;
	logic [BYTES_CFG_W-1:0] bytes_cfg_q;

	logic      cmd_push;
	cmd_t      cmd;
	logic      cmd_pop;
	cmd_t      cmd_head;
	q_status_t q_status;

	// Hold the configuration; the user must write only while the ring is idle (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_cfg_q <= SLOTS_CFG_W'(8);
			bytes_cfg_q <= BYTES_CFG_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLOTS_IN_USE: slots_cfg_q <= cfg_data[SLOTS_CFG_W-1:0];
				CFG_SLOT_BYTES:   bytes_cfg_q <= cfg_data[BYTES_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: classify each beat against the slot pointers and advance them
	msbr_front #(
		.MAX_SLOTS      (MAX_SLOTS),
		.MAX_SLOT_BYTES (MAX_SLOT_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.slots_cfg (slots_cfg_q),
		.bytes_cfg (bytes_cfg_q),
		.q_status  (q_status),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	// Decouple classification from the store so each side can stall alone
	msbr_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.cmd_in   (cmd),
		.pop      (cmd_pop),
		.head     (cmd_head),
		.q_status (q_status)
	);

	// Back end: own the store, write bytes, stream slots and status beats
	msbr_back #(
		.MAX_SLOTS      (MAX_SLOTS),
		.MAX_SLOT_BYTES (MAX_SLOT_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (cmd_head),
		.q_status  (q_status),
		.pop       (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// The back end takes a command only when one is waiting
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> q_status.valid)
		else $error("command popped from an empty queue");

	// A command pushed and not taken leaves the queue occupied
	a_push_held: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd_push) && !$past(cmd_pop) |-> q_status.valid)
		else $error("pushed command lost from the queue");

	// A status answer is always the only and final beat of its read
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STAT_DATA) |-> rsp.last && (rsp.read_byte == '0))
		else $error("status beat without last or with data");

endmodule

>>> tb/tb_multi_slot_buffer_ring.sv
`timescale 1ns / 100ps

module tb_multi_slot_buffer_ring;
	import msbr_pkg::*;

	localparam int RING_DEPTH           = MAX_SLOTS_DEF * MAX_SLOT_BYTES_DEF;
	localparam int SETTLE_CYCLES        = 16;
	localparam int MISMATCH_PRINT_LIMIT = 40;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_stall;
	req_t                   req       = '0;
	logic                   rsp_valid;
	logic                   rsp_stall = 1'b0;
	rsp_t                   rsp;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	multi_slot_buffer_ring dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Our own picture of the ring: register copies, pointers and the byte store. A flag per
	// store byte records whether it has ever been written, so that the stimulus never asks
	// for a byte the hardware holds no defined value for.
	logic [SLOTS_CFG_W-1:0] ring_slots_reg = 4'd8;
	logic [BYTES_CFG_W-1:0] ring_bytes_reg = 7'd64;
	int unsigned            wr_slot        = 0;
	int unsigned            rd_slot        = 0;
	int unsigned            fill_pos       = 0;
	logic [BYTE_W-1:0]      ring_store   [RING_DEPTH];
	bit                     ring_written [RING_DEPTH];

	// Beats still owed by the block, oldest first
	rsp_t pending_beats[$];

	int unsigned sender_idle_pct    = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned mismatch_count     = 0;
	int unsigned items_sent         = 0;
	int unsigned data_beats_checked = 0;
	int unsigned status_beats_checked = 0;

	// Out-of-range register values clamp to the legal span
	function automatic int unsigned slot_count();
		if (ring_slots_reg < 2) return 2;
		if (ring_slots_reg > MAX_SLOTS_DEF) return MAX_SLOTS_DEF;
		return ring_slots_reg;
	endfunction

	function automatic int unsigned slot_size();
		if (ring_bytes_reg < 1) return 1;
		if (ring_bytes_reg > MAX_SLOT_BYTES_DEF) return MAX_SLOT_BYTES_DEF;
		return ring_bytes_reg;
	endfunction

	// A pointer left beyond the ring by a shrink wraps to slot 0 on its next step
	function automatic int unsigned advance_slot(input int unsigned s);
		return (s + 1 >= slot_count()) ? 0 : s + 1;
	endfunction

	// Count the bytes of the read slot that have been written, from position 0 onwards
	function automatic int unsigned readable_bytes();
		int unsigned n = 0;
		while (n < slot_size() && ring_written[rd_slot * MAX_SLOT_BYTES_DEF + n])
			n++;
		return n;
	endfunction

	function automatic req_t make_item(input logic act, input logic [BYTE_W-1:0] data,
			input logic [LEN_W-1:0] len);
		req_t item;
		item.action      = act;
		item.write_byte  = data;
		item.read_length = len;
		return item;
	endfunction

	// Apply one accepted beat to the ring picture and queue the beats it must produce.
	// The empty check wins over the length check; a bad length moves nothing.
	task automatic predict_ring(input req_t item);
		int unsigned idx;
		rsp_t beat;
		if (item.action == ACT_WRITE) begin
			idx = wr_slot * MAX_SLOT_BYTES_DEF + fill_pos;
			ring_store[idx]   = item.write_byte;
			ring_written[idx] = 1'b1;
			if (fill_pos + 1 >= slot_size()) begin
				fill_pos = 0;
				wr_slot  = advance_slot(wr_slot);
			end else begin
				fill_pos++;
			end
		end else if (rd_slot == wr_slot) begin
			beat.status    = STAT_EMPTY;
			beat.read_byte = '0;
			beat.last      = 1'b1;
			pending_beats.push_back(beat);
		end else if (item.read_length == 0 || item.read_length > slot_size()) begin
			beat.status    = STAT_BAD_LENGTH;
			beat.read_byte = '0;
			beat.last      = 1'b1;
			pending_beats.push_back(beat);
		end else begin
			for (int k = 0; k < item.read_length; k++) begin
				beat.status    = STAT_DATA;
				beat.read_byte = ring_store[rd_slot * MAX_SLOT_BYTES_DEF + k];
				beat.last      = (k + 1 == item.read_length);
				pending_beats.push_back(beat);
			end
			rd_slot = advance_slot(rd_slot);
		end
	endtask

	task automatic report_mismatch(input string what);
		if (mismatch_count < MISMATCH_PRINT_LIMIT)
			$display("MISMATCH at %0t ns: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Present one beat, with random idle cycles ahead of it, and hold it until accepted.
	// Called just after a rising edge; returns just after the accepting edge.
	task automatic send_item(input req_t item);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
		predict_ring(item);
	endtask

	// Write both registers on consecutive edges; only called with the block idle
	task automatic configure_ring(input logic [SLOTS_CFG_W-1:0] slots,
			input logic [BYTES_CFG_W-1:0] bytes);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SLOTS_IN_USE;
		cfg_data  <= CFG_DATA_W'(slots);
		@(posedge clk);
		ring_slots_reg = slots;
		cfg_index <= CFG_SLOT_BYTES;
		cfg_data  <= bytes;
		@(posedge clk);
		ring_bytes_reg = bytes;
		cfg_we <= 1'b0;
	endtask

	// Drop valid, wait for every owed beat, then give trailing writes time to land
	task automatic settle_ring();
		req_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly fill-then-drain traffic: reads only ask for bytes that exist. About one
	// beat in ten is noise: a read of an empty ring or an illegal length.
	function automatic req_t random_item(input int unsigned read_pct);
		req_t item;
		int unsigned ready;
		int unsigned roll;
		item.action      = ACT_WRITE;
		item.write_byte  = BYTE_W'($urandom_range(255));
		item.read_length = LEN_W'($urandom_range(127));
		ready = (rd_slot == wr_slot) ? 0 : readable_bytes();
		roll  = $urandom_range(99);
		if (roll < 10) begin
			item.action = ACT_READ;
			if (rd_slot != wr_slot) begin
				if ($urandom_range(3) == 0)
					item.read_length = '0;
				else
					item.read_length = LEN_W'($urandom_range(127, slot_size() + 1));
			end
		end else if (ready != 0 && roll < 10 + read_pct) begin
			item.action = ACT_READ;
			item.read_length = LEN_W'($urandom_range(1) ? ready : $urandom_range(ready, 1));
		end
		return item;
	endfunction

	task automatic run_random_items(input int unsigned count, input int unsigned read_pct);
		repeat (count) send_item(random_item(read_pct));
	endtask

	// Reads on a fresh ring answer empty whatever the length, illegal or not
	task automatic test_empty_ring_reads();
		send_item(make_item(ACT_READ, 8'h00, 7'd0));
		send_item(make_item(ACT_READ, 8'hFF, 7'd64));
		send_item(make_item(ACT_READ, 8'h00, 7'd127));
		settle_ring();
	endtask

	// Both registers at zero clamp to two slots of one byte: illegal lengths, a good read,
	// then a writer that laps the reader so the ring looks empty while holding data
	task automatic test_tiny_ring();
		configure_ring(4'd0, 7'd0);
		send_item(make_item(ACT_WRITE, 8'h00, 7'd127));
		send_item(make_item(ACT_READ,  8'h00, 7'd0));
		send_item(make_item(ACT_READ,  8'h00, 7'd2));
		send_item(make_item(ACT_READ,  8'h00, 7'd1));
		send_item(make_item(ACT_READ,  8'h00, 7'd1));
		send_item(make_item(ACT_WRITE, 8'hFF, 7'd0));
		send_item(make_item(ACT_WRITE, 8'hA5, 7'd0));
		send_item(make_item(ACT_READ,  8'h00, 7'd1));
		send_item(make_item(ACT_WRITE, 8'h5A, 7'd0));
		send_item(make_item(ACT_READ,  8'h00, 7'd1));
		settle_ring();
	endtask

	// Leave both pointers on slot 3 with a part-filled slot, then shrink to three slots of
	// one byte: the next write completes the slot and both pointers wrap to 0
	task automatic test_shrunk_ring();
		configure_ring(4'd8, 7'd2);
		for (int k = 0; k < 7; k++)
			send_item(make_item(ACT_WRITE, 8'(8'h81 + 8'd23 * k), 7'd0));
		repeat (3) send_item(make_item(ACT_READ, 8'h00, 7'd2));
		settle_ring();
		configure_ring(4'd3, 7'd1);
		send_item(make_item(ACT_READ,  8'h00, 7'd1));
		send_item(make_item(ACT_WRITE, 8'h3C, 7'd0));
		send_item(make_item(ACT_READ,  8'h00, 7'd1));
		send_item(make_item(ACT_READ,  8'h00, 7'd1));
		settle_ring();
	endtask

	task automatic test_small_slot_traffic();
		configure_ring(4'd3, 7'd5);
		run_random_items(100, 35);
		settle_ring();
	endtask

	// Registers above range clamp to the largest ring; write-heavy so full slots get read
	task automatic test_full_size_traffic();
		configure_ring(4'd15, 7'd127);
		run_random_items(130, 25);
		settle_ring();
	endtask

	task automatic test_back_to_back_traffic();
		configure_ring(4'd1, 7'd3);
		run_random_items(100, 35);
		settle_ring();
	endtask

	// Receiver: stall at random at the current rate
	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

	// Check each accepted response beat against the oldest owed one, field by field
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat: status %0d byte %02h last %0b",
					rsp.status, rsp.read_byte, rsp.last));
			end else begin
				want = pending_beats.pop_front();
				if (want.status == STAT_DATA)
					data_beats_checked++;
				else
					status_beats_checked++;
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, want.status));
				if (rsp.read_byte !== want.read_byte)
					report_mismatch($sformatf("read_byte %02h, expected %02h",
						rsp.read_byte, want.read_byte));
				if (rsp.last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b",
						rsp.last, want.last));
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly and the receiver heavily, then the other way round,
		// then both run flat out
		sender_idle_pct    = 33;
		receiver_stall_pct = 71;
		test_empty_ring_reads();
		test_tiny_ring();
		test_shrunk_ring();
		test_small_slot_traffic();

		sender_idle_pct    = 71;
		receiver_stall_pct = 33;
		test_full_size_traffic();

		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		test_back_to_back_traffic();

		$display("Ring run: %0d request beats, %0d data bytes and %0d status answers checked",
			items_sent, data_beats_checked, status_beats_checked);
		$display("Ring sizes covered: clamped 2x1 up to clamped 8x64, with shrink and overrun");
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("Verification failed");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#10_000_000;
		$display("Timed out with %0d beats still owed", pending_beats.size());
		$display("Verification failed");
		$finish;
	end

endmodule
